// ===== design/tlapt_pkg.sv =====
// ----------------------------------------------------------------------------
// tlapt_pkg
// shared constants, types and the arctangent table for the arm tracker
// ----------------------------------------------------------------------------
package tlapt_pkg;

    localparam int TABLE_LEN = 24;
    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FORE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP   = 3'd4;

    localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam logic [18:0] JUMP_RESET = 19'd1600;
    localparam logic signed [31:0] SUM_RESET = 32'sd1600;

    // cordic request and reply between sequencer and rotator
    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic               done;
        logic signed [33:0] cos_q30;
        logic signed [33:0] sin_q30;
    } cordic_rsp_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/tlapt_cordic.sv =====
// ----------------------------------------------------------------------------
// tlapt_cordic
// iterative rotation-mode cordic, one micro-rotation per cycle
// ----------------------------------------------------------------------------
module tlapt_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tlapt_pkg::cordic_req_t req,
    output tlapt_pkg::cordic_rsp_t rsp
);
    localparam int NSTEP = (CORDIC_STEPS < tlapt_pkg::TABLE_LEN) ?
                           CORDIC_STEPS : tlapt_pkg::TABLE_LEN;

    logic               busy_reg, busy_next;
    logic [4:0]         step_reg, step_next;
    logic [1:0]         quad_reg, quad_next;
    logic signed [33:0] x_reg, x_next, y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic               done_reg, done_next;
    logic [31:0]        qa;
    logic signed [33:0] xs, ys, at;

    always_comb
    begin
        qa        = req.angle + 32'h20000000;
        xs        = x_reg >>> step_reg;
        ys        = y_reg >>> step_reg;
        at        = {2'b00, tlapt_pkg::atan_entry(step_reg)};
        busy_next = busy_reg;
        step_next = step_reg;
        quad_next = quad_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = 5'd0;
            quad_next = qa[31:30];
            x_next    = tlapt_pkg::INV_GAIN_Q30;
            y_next    = '0;
            z_next    = 34'(signed'(req.angle - {qa[31:30], 30'd0}));
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            step_next = step_reg + 5'd1;
            if (step_reg == 5'(NSTEP - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quad_reg <= quad_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    always_comb
    begin
        rsp.done = done_reg;
        case (quad_reg)
            2'd0:    begin rsp.cos_q30 = x_reg;  rsp.sin_q30 = y_reg;  end
            2'd1:    begin rsp.cos_q30 = -y_reg; rsp.sin_q30 = x_reg;  end
            2'd2:    begin rsp.cos_q30 = -x_reg; rsp.sin_q30 = -y_reg; end
            default: begin rsp.cos_q30 = y_reg;  rsp.sin_q30 = -x_reg; end
        endcase
    end

    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |=> !rsp.done)
        else $error("cordic done held");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !req.start |-> !rsp.done)
        else $error("done while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> $past(busy_reg))
        else $error("done without run");
endmodule

// ===== design/three_link_arm_position_tracker.sv =====
// ----------------------------------------------------------------------------
// three_link_arm_position_tracker
// forward kinematics of a three-joint arm with displacement and accumulation
// ----------------------------------------------------------------------------
// sequence: three cordic rotations (base, shoulder, shoulder plus elbow), then
//   multiply-accumulate and update, then the result goes to the output register
// flow: s_tready is low while a word is in work, a finished word waits in the
//   output register and the next one may enter
// reset: links clear to 0, jump limit to 100 mm, last position to 0,
//   accumulated position to 100 mm; no clearing pass
module three_link_arm_position_tracker #(
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // base_angle, shoulder_angle, elbow_angle, zero pad to bytes
    input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pos_x, pos_y, pos_z, delta_x, delta_y, delta_z, accum_x, accum_y,
    // accum_z, accepted, zero pad (256 bits)
    output logic [255:0]          m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [18:0]           cfg_data
);
    localparam int AW = ANGLE_BITS;
    // 100 mm in link units
    localparam logic [18:0]        JUMP_RST = 19'(100 << FRAC_BITS);
    localparam logic signed [31:0] SUM_RST  = 32'(100 << FRAC_BITS);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_TRIG = 6'b000010,
        ST_MAC  = 6'b000100,
        ST_XY   = 6'b001000,
        ST_UPD  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] l0_reg, l1_reg, l2_reg, l3_reg;
    logic [18:0] jump_reg;
    logic signed [19:0] last_x_reg, last_y_reg, last_z_reg;
    logic signed [31:0] sum_x_reg, sum_y_reg, sum_z_reg;

    logic [AW-1:0] a0_reg, a1_reg, a12_reg;
    logic [1:0]    tsel_reg;
    logic signed [33:0] c0_reg, s0_reg, c1_reg, s1_reg, c12_reg, s12_reg;
    logic [3:0]    mstep_reg;
    logic signed [63:0] acc_reg, prod_reg;
    logic signed [63:0] r_reg, pz_reg;
    logic signed [19:0] nx_reg, ny_reg, nz_reg;
    logic          out_full_reg;
    logic [255:0]  out_reg;

    tlapt_pkg::cordic_req_t creq;
    tlapt_pkg::cordic_rsp_t crsp;

    tlapt_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp)
    );

    logic in_acc;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_full_reg;
    assign m_tdata   = out_reg;

    // angle for the next rotation: base, then shoulder, then shoulder plus elbow
    logic [AW-1:0] next_ang;
    always_comb
    begin
        case (tsel_reg)
            2'd2:    next_ang = a1_reg;
            2'd0:    next_ang = a12_reg;
            default: next_ang = a0_reg;
        endcase
    end

    logic [AW-1:0] in_a0, in_a1, in_a12;
    always_comb
    begin
        in_a0  = s_tdata[AW-1:0];
        in_a1  = AW'(0) - s_tdata[2*AW-1:AW];
        in_a12 = in_a1 + (s_tdata[3*AW-1:2*AW] - {1'b1, {(AW-1){1'b0}}});
    end

    always_comb
    begin
        creq.start = 1'b0;
        creq.angle = {a0_reg, {(32-AW){1'b0}}};
        if (in_acc)
        begin
            creq.start = 1'b1;
            creq.angle = {in_a0, {(32-AW){1'b0}}};
        end
        else if (state_reg == ST_TRIG && crsp.done && tsel_reg != 2'd1)
        begin
            creq.start = 1'b1;
            creq.angle = {next_ang, {(32-AW){1'b0}}};
        end
    end

    // shared multiplier: one 34x34 signed product per cycle
    logic signed [33:0] ma, mb;
    logic signed [67:0] mprod;
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (mstep_reg)
            4'd0: begin ma = 34'(signed'({1'b0, l1_reg})); mb = c1_reg;  end
            4'd1: begin ma = 34'(signed'({1'b0, l2_reg})); mb = c12_reg; end
            4'd2: begin ma = 34'(signed'({1'b0, l3_reg})); mb = s12_reg; end
            4'd4: begin ma = 34'(signed'({1'b0, l1_reg})); mb = s1_reg;  end
            4'd5: begin ma = 34'(signed'({1'b0, l2_reg})); mb = s12_reg; end
            4'd6: begin ma = 34'(signed'({1'b0, l3_reg})); mb = c12_reg; end
            4'd8: begin ma = r_reg[33:0];                  mb = c0_reg;  end
            4'd9: begin ma = r_reg[33:0];                  mb = s0_reg;  end
            default: ;
        endcase
        mprod = ma * mb;
    end

    function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + 64'sd536870912;
        return t >>> 30;
    endfunction

    function automatic logic signed [19:0] sat20(input logic signed [63:0] v);
        if (v > 64'sd524287) return 20'sd524287;
        if (v < -64'sd524288) return -20'sd524288;
        return v[19:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        if (v > 33'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -33'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    logic signed [20:0] dx, dy, dz;
    logic               ok;
    logic signed [31:0] sx, sy, sz;
    always_comb
    begin
        dx = 21'(nx_reg) - 21'(last_x_reg);
        dy = 21'(ny_reg) - 21'(last_y_reg);
        dz = 21'(nz_reg) - 21'(last_z_reg);
        ok = (dx < $signed({2'b00, jump_reg})) && (dy < $signed({2'b00, jump_reg}))
             && (dz < $signed({2'b00, jump_reg}));
        sx = ok ? sat32(33'(sum_x_reg) + 33'(dx)) : sum_x_reg;
        sy = ok ? sat32(33'(sum_y_reg) + 33'(dy)) : sum_y_reg;
        sz = ok ? sat32(33'(sum_z_reg) + 33'(dz)) : sum_z_reg;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_acc) state_next = ST_TRIG;
            ST_TRIG: if (crsp.done && tsel_reg == 2'd1) state_next = ST_MAC;
            ST_MAC:  if (mstep_reg == 4'd7) state_next = ST_XY;
            ST_XY:   if (mstep_reg == 4'd11) state_next = ST_UPD;
            ST_UPD:  state_next = ST_OUT;
            ST_OUT:  if (!out_full_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            out_full_reg <= 1'b0;
            tsel_reg     <= 2'd2;
            mstep_reg    <= '0;
            l0_reg       <= '0;
            l1_reg       <= '0;
            l2_reg       <= '0;
            l3_reg       <= '0;
            jump_reg     <= JUMP_RST;
            last_x_reg   <= '0;
            last_y_reg   <= '0;
            last_z_reg   <= '0;
            sum_x_reg    <= SUM_RST;
            sum_y_reg    <= SUM_RST;
            sum_z_reg    <= SUM_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tlapt_pkg::REG_BASE:   l0_reg   <= cfg_data[15:0];
                    tlapt_pkg::REG_UPPER:  l1_reg   <= cfg_data[15:0];
                    tlapt_pkg::REG_FORE:   l2_reg   <= cfg_data[15:0];
                    tlapt_pkg::REG_OFFSET: l3_reg   <= cfg_data[15:0];
                    tlapt_pkg::REG_JUMP:   jump_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (in_acc)
            begin
                tsel_reg  <= 2'd2;
                mstep_reg <= '0;
            end
            else if (state_reg == ST_TRIG && crsp.done)
            begin
                tsel_reg <= (tsel_reg == 2'd2) ? 2'd0 : 2'd1;
            end
            if (state_reg == ST_MAC || state_reg == ST_XY)
                mstep_reg <= mstep_reg + 4'd1;
            // a new word may replace the one leaving in the same cycle
            if (state_reg == ST_OUT && (!out_full_reg || m_tready))
                out_full_reg <= 1'b1;
            else if (out_full_reg && m_tready)
                out_full_reg <= 1'b0;
            if (state_reg == ST_UPD)
            begin
                last_x_reg <= nx_reg;
                last_y_reg <= ny_reg;
                last_z_reg <= nz_reg;
                sum_x_reg  <= sx;
                sum_y_reg  <= sy;
                sum_z_reg  <= sz;
            end
        end
    end

    logic signed [20:0] dx_reg, dy_reg, dz_reg;
    logic               ok_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a0_reg  <= in_a0;
            a1_reg  <= in_a1;
            a12_reg <= in_a12;
        end
        if (state_reg == ST_TRIG && crsp.done)
        begin
            case (tsel_reg)
                2'd2:    begin c0_reg <= crsp.cos_q30;  s0_reg <= crsp.sin_q30;  end
                2'd0:    begin c1_reg <= crsp.cos_q30;  s1_reg <= crsp.sin_q30;  end
                default: begin c12_reg <= crsp.cos_q30; s12_reg <= crsp.sin_q30; end
            endcase
        end
        prod_reg <= mprod[63:0];
        // product of step n lands in prod_reg at step n+1
        case (mstep_reg)
            4'd1: acc_reg <= prod_reg;
            4'd2: acc_reg <= acc_reg - prod_reg;
            4'd3: r_reg   <= rnd30(acc_reg - prod_reg);
            4'd5: acc_reg <= prod_reg;
            4'd6: acc_reg <= acc_reg - prod_reg;
            4'd7: pz_reg  <= 64'(l0_reg) + rnd30(acc_reg + prod_reg);
            4'd9: nx_reg  <= sat20(rnd30(prod_reg));
            4'd10: ny_reg <= sat20(rnd30(prod_reg));
            4'd11: nz_reg <= sat20(pz_reg);
            default: ;
        endcase
        if (state_reg == ST_UPD)
        begin
            dx_reg <= dx;
            dy_reg <= dy;
            dz_reg <= dz;
            ok_reg <= ok;
        end
        if (state_reg == ST_OUT && (!out_full_reg || m_tready))
            out_reg <= {36'd0, ok_reg, sum_z_reg, sum_y_reg, sum_x_reg,
                        dz_reg, dy_reg, dx_reg, last_z_reg, last_y_reg, last_x_reg};
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("accepting while busy");
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == ST_TRIG)
        else $error("accept without run");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
endmodule
